// ===== sv/bmcd_pkg.sv =====
// shared types, opcodes and constants of the bitmask code decompressor
package bmcd_pkg;

  // codeword opcodes
  localparam logic [2:0] OpRaw     = 3'b000;
  localparam logic [2:0] OpRepeat  = 3'b001;
  localparam logic [2:0] OpMask    = 3'b010;
  localparam logic [2:0] OpFlip1   = 3'b011;
  localparam logic [2:0] OpFlip2   = 3'b100;
  localparam logic [2:0] OpFlip4   = 3'b101;
  localparam logic [2:0] OpTwoAny  = 3'b110;
  localparam logic [2:0] OpPlain   = 3'b111;

  // input kinds carried on tuser
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdBit  = 1'b1;

  // design constants
  localparam int DictEntriesDefault = 16;
  localparam int QueueDepthDefault  = 4;
  localparam int WordW              = 32;
  localparam int DictIdxW           = 4;
  localparam int CountW             = 6;
  localparam int RepW               = 3;

  // decoded work handed from front to back
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             rep;
    logic [RepW-1:0]  cnt;
  } entry_t;

  // payload length in bits for each opcode
  function automatic logic [CountW-1:0] payload_len(input logic [2:0] op);
    logic [CountW-1:0] len;
    unique case (op)
      OpRaw:    len = 6'd32;
      OpRepeat: len = 6'd3;
      OpMask:   len = 6'd13;
      OpFlip1:  len = 6'd9;
      OpFlip2:  len = 6'd9;
      OpFlip4:  len = 6'd9;
      OpTwoAny: len = 6'd14;
      OpPlain:  len = 6'd4;
      default:  len = 6'd32;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/bmcd_front.sv =====
// front end: dictionary store, codeword framing and word reconstruction
module bmcd_front #(
  parameter int DICT_ENTRIES = bmcd_pkg::DictEntriesDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       cmd,
  input  logic [bmcd_pkg::DictIdxW-1:0] dict_index,
  input  logic [bmcd_pkg::WordW-1:0] dict_word,
  input  logic                       stream_bit,
  input  logic                       end_of_stream,
  output logic                       push,
  output bmcd_pkg::entry_t           push_entry
);

  localparam int IdxW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam logic [bmcd_pkg::DictIdxW:0] DictLimit = (bmcd_pkg::DictIdxW+1)'(DICT_ENTRIES);

  logic [bmcd_pkg::WordW-1:0]  dict_r [DICT_ENTRIES];
  logic [bmcd_pkg::WordW-1:0]  buf_r, buf_nxt;
  logic [bmcd_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [2:0]                  op_r, op_nxt;
  logic                        bit_xfer;
  logic                        complete;
  logic [bmcd_pkg::WordW-1:0]  dword;
  logic [bmcd_pkg::WordW-1:0]  word;
  logic [4:0]                  pos_a, pos_b;
  logic [bmcd_pkg::DictIdxW-1:0] rd_idx;

  assign bit_xfer = accept && (cmd == bmcd_pkg::CmdBit);

  // framing: shift in the bit, latch the opcode on the third bit
  always_comb begin
    buf_nxt  = {buf_r[bmcd_pkg::WordW-2:0], stream_bit};
    cnt_nxt  = cnt_r + 6'd1;
    op_nxt   = (cnt_r == 6'd2) ? buf_nxt[2:0] : op_r;
    complete = bit_xfer && (cnt_r >= 6'd2) &&
               (cnt_nxt == 6'd3 + bmcd_pkg::payload_len(op_nxt));
  end

  // dictionary read, out of range reads zero
  assign rd_idx = buf_nxt[3:0];
  always_comb begin
    if ({1'b0, rd_idx} < DictLimit) begin
      dword = dict_r[rd_idx[IdxW-1:0]];
    end else begin
      dword = '0;
    end
  end

  // rebuild the instruction from the payload
  assign pos_a = buf_nxt[8:4];
  assign pos_b = buf_nxt[13:9];
  always_comb begin
    unique case (op_nxt)
      bmcd_pkg::OpRaw:    word = buf_nxt;
      bmcd_pkg::OpMask:   word = dword ^ ({buf_nxt[7:4], 28'd0} >> buf_nxt[12:8]);
      bmcd_pkg::OpFlip1:  word = dword ^ (32'h8000_0000 >> pos_a);
      bmcd_pkg::OpFlip2:  word = dword ^ (32'hC000_0000 >> pos_a);
      bmcd_pkg::OpFlip4:  word = dword ^ (32'hF000_0000 >> pos_a);
      bmcd_pkg::OpTwoAny: word = dword ^ (32'h8000_0000 >> pos_b)
                                 ^ (32'h8000_0000 >> pos_a);
      default:            word = dword;
    endcase
  end

  assign push             = complete;
  assign push_entry.word  = word;
  assign push_entry.rep   = (op_nxt == bmcd_pkg::OpRepeat);
  assign push_entry.cnt   = buf_nxt[2:0];

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
      op_r  <= '0;
    end else if (bit_xfer) begin
      if (complete || end_of_stream) begin
        buf_r <= '0;
        cnt_r <= '0;
      end else begin
        buf_r <= buf_nxt;
        cnt_r <= cnt_nxt;
      end
      op_r <= op_nxt;
    end
  end

  // dictionary writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DICT_ENTRIES; i++) begin
        dict_r[i] <= '0;
      end
    end else if (accept && (cmd == bmcd_pkg::CmdLoad) && ({1'b0, dict_index} < DictLimit)) begin
      dict_r[dict_index[IdxW-1:0]] <= dict_word;
    end
  end

endmodule

// ===== sv/bmcd_queue.sv =====
// short queue of decoded entries between front and back
module bmcd_queue #(
  parameter int DEPTH = bmcd_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bmcd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output bmcd_pkg::entry_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bmcd_pkg::entry_t    mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bmcd_back.sv =====
// back end: repeat expansion, previous instruction and output register
module bmcd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bmcd_pkg::entry_t           q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bmcd_pkg::WordW-1:0] out_word,
  output logic                       out_last
);

  logic                         valid_r;
  logic [bmcd_pkg::WordW-1:0]   word_r;
  logic                         last_r;
  logic [bmcd_pkg::WordW-1:0]   prev_r;
  logic                         rep_r;
  logic [bmcd_pkg::RepW-1:0]    rem_r;
  logic                         load;

  // output slot is free or being emptied this cycle
  assign load  = !valid_r || out_ready;
  assign q_pop = load && !rep_r && q_valid;

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prev_r  <= '0;
      rep_r   <= 1'b0;
      rem_r   <= '0;
    end else if (load) begin
      priority if (rep_r) begin
        // ongoing repeat burst
        valid_r <= 1'b1;
        word_r  <= prev_r;
        last_r  <= (rem_r == '0);
        rep_r   <= (rem_r != '0);
        rem_r   <= rem_r - 1'b1;
      end else if (q_valid && q_head.rep) begin
        // first copy of a repeat
        valid_r <= 1'b1;
        word_r  <= prev_r;
        last_r  <= (q_head.cnt == '0);
        rep_r   <= (q_head.cnt != '0);
        rem_r   <= q_head.cnt - 1'b1;
      end else if (q_valid) begin
        // single decoded instruction
        valid_r <= 1'b1;
        word_r  <= q_head.word;
        last_r  <= 1'b1;
        prev_r  <= q_head.word;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/bitmask_code_decompressor_core.sv =====
// top level of the bitmask code decompressor
// Input channel in_*: one transfer is either a dictionary load (in_tuser 0)
// or one compressed stream bit (in_tuser 1), bits most significant first.
// in_tlast on a stream bit ends the stream: a codeword finished by that bit
// is still decoded, a partial codeword is dropped. Loads write slot
// dict_index of the dictionary at once and never produce output.
// Output channel out_*: one decompressed instruction per transfer; out_tlast
// marks the final instruction caused by one input transfer (a repeat
// codeword gives up to eight).
// The bit that completes a codeword is decoded in the accepting cycle and
// queued; the output register is loaded from the queue. Throughput is one
// input transfer per cycle while in_tready is high and one instruction per
// cycle while out_tready is high; the decoded-entry queue decouples the two,
// and in_tready drops only while that queue is full, which happens when
// repeat bursts or a stalled receiver hold the output back.
// Reset clears the dictionary, the previous instruction, framing, queue and
// output valid flag; no clearing pass is needed. A stalled receiver holds the
// current result stable.
module bitmask_code_decompressor_core #(
  parameter int DICT_ENTRIES = bmcd_pkg::DictEntriesDefault,
  parameter int QUEUE_DEPTH  = bmcd_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // dict_index[3:0], dict_word[35:4], stream_bit[36], zero pad
  input  logic        in_tuser,   // cmd
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // instruction[31:0]
  output logic        out_tlast   // last_of_run
);

  logic             in_xfer;
  logic             push;
  bmcd_pkg::entry_t push_entry;
  logic             pop;
  logic             full;
  logic             q_valid;
  bmcd_pkg::entry_t q_head;

  assign in_tready = !full;
  assign in_xfer   = in_tvalid && in_tready;

  // front: classify and decode
  bmcd_front #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .cmd          (in_tuser),
    .dict_index   (in_tdata[3:0]),
    .dict_word    (in_tdata[35:4]),
    .stream_bit   (in_tdata[36]),
    .end_of_stream(in_tlast),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoupling queue
  bmcd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // back: expand and deliver
  bmcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_word (out_tdata),
    .out_last (out_tlast)
  );

endmodule
